FILE: rtl/pedal_plausibility_fault_manager_unit_macros.svh
// Assertion macros shared by the pedal plausibility fault manager RTL.
`ifndef PEDAL_PLAUSIBILITY_FAULT_MANAGER_UNIT_MACROS_SVH
`define PEDAL_PLAUSIBILITY_FAULT_MANAGER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and held off while arst_n is low.
`define PPFM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off while arst_n is low.
`define PPFM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/ppfm_pkg.sv
// Shared constants, codes and types of the pedal plausibility fault manager.
package ppfm_pkg;

	// Scaling and torque shaping constants.
	localparam int PEDAL_FULL_SCALE = 255;
	localparam int TORQUE_SCALE     = 10;
	localparam int TORQUE_DEADBAND  = 20;
	localparam int TORQUE_KNEE      = 2300;
	localparam int TORQUE_CEIL      = 2540;

	// Fixed field widths.
	localparam int RAW_W      = 12;
	localparam int CNT_W      = RAW_W - 2;
	localparam int OUT_W      = 8;
	localparam int MIS_W      = 8;
	localparam int TIM_W      = 16;
	localparam int MASK_W     = 8;
	localparam int TRQ_OUT_W  = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Widths that follow from the scaling constants.
	localparam int SCL_W  = $clog2(PEDAL_FULL_SCALE + 1);
	localparam int NUM_W  = CNT_W + SCL_W;
	localparam int STEP_W = $clog2(NUM_W);
	localparam int CMP_W  = (SCL_W > OUT_W) ? SCL_W : OUT_W;
	localparam int TS_W   = $clog2(TORQUE_SCALE + 1);
	localparam int TQ_W   = (SCL_W + TS_W > TRQ_OUT_W) ? SCL_W + TS_W : TRQ_OUT_W;

	// Fault mask bit positions.
	localparam int MASK_BSPD_LATCH   = 0;
	localparam int MASK_BSPD_OPEN    = 1;
	localparam int MASK_INERTIA_OPEN = 2;
	localparam int MASK_LEFT_OOR     = 3;
	localparam int MASK_RIGHT_OOR    = 4;
	localparam int MASK_MISMATCH     = 5;
	localparam int MASK_TIMEOUT      = 6;
	localparam int MASK_OVERLAP      = 7;

	typedef enum logic [1:0] {
		MODE_FAULT   = 2'd0,
		MODE_BRAKING = 2'd1,
		MODE_RUN     = 2'd2
	} drive_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEFT_MIN      = 3'd0,
		REG_LEFT_MAX      = 3'd1,
		REG_RIGHT_MIN     = 3'd2,
		REG_RIGHT_MAX     = 3'd3,
		REG_MISMATCH      = 3'd4,
		REG_TIME_LIMIT    = 3'd5,
		REG_OVERLAP_HIGH  = 3'd6,
		REG_OVERLAP_LOW   = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0] left_min;
		logic [CNT_W-1:0] left_max;
		logic [CNT_W-1:0] right_min;
		logic [CNT_W-1:0] right_max;
		logic [MIS_W-1:0] mismatch_limit;
		logic [TIM_W-1:0] time_limit;
		logic [OUT_W-1:0] overlap_high;
		logic [OUT_W-1:0] overlap_low;
	} cfg_t;

	typedef struct packed {
		logic brake;
		logic bspd;
		logic seg_closed;
		logic inertia;
	} flags_t;

	typedef struct packed {
		logic             done;
		logic             oor;
		logic [SCL_W-1:0] scaled;
	} lane_out_t;

	typedef struct packed {
		logic [OUT_W-1:0]     left_scaled;
		logic [OUT_W-1:0]     right_scaled;
		logic [MASK_W-1:0]    fault_mask;
		drive_mode_t          drive_mode;
		logic [TRQ_OUT_W-1:0] torque;
		logic                 cal_bad;
		logic [TIM_W-1:0]     elapsed;
	} res_t;

endpackage

FILE: rtl/ppfm_lane.sv
// One pedal channel: offset removal and bit-serial scaling division with clipping.
`include "pedal_plausibility_fault_manager_unit_macros.svh"

module ppfm_lane (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ppfm_pkg::RAW_W-1:0]  raw,
	input  logic [ppfm_pkg::CNT_W-1:0]  lo,
	input  logic [ppfm_pkg::CNT_W-1:0]  hi,
	output ppfm_pkg::lane_out_t         lane_o
);
	import ppfm_pkg::*;

	logic [CNT_W-1:0]  sample;
	logic              below;
	logic [NUM_W-1:0]  numer;
	logic [NUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  div_q;
	logic              below_q;
	logic [STEP_W-1:0] cnt_q;
	logic              run_q;
	logic              done_q;
	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    trial_sub;
	logic              fits;
	logic              over;

	// Drop the two low ADC bits and remove the calibrated offset.
	assign sample = raw[RAW_W-1:2];
	assign below  = sample < lo;
	assign numer  = NUM_W'(sample - lo) * NUM_W'(PEDAL_FULL_SCALE);

	// One restoring division step: shift in the next dividend bit, subtract if it fits.
	assign trial     = {rem_q, quo_q[NUM_W-1]};
	assign trial_sub = trial - {1'b0, div_q};
	assign fits      = trial >= {1'b0, div_q};

	// Sequencing of the division steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= STEP_W'(NUM_W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Dividend, remainder and divisor registers.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q   <= numer;
			rem_q   <= '0;
			div_q   <= hi - lo;
			below_q <= below;
		end else if (run_q) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
		end
	end

	// Clip the quotient to full scale; a clip either way marks the channel out of range.
	assign over          = quo_q > NUM_W'(PEDAL_FULL_SCALE);
	assign lane_o.done   = done_q;
	assign lane_o.oor    = below_q | over;
	assign lane_o.scaled = below_q ? '0 : (over ? SCL_W'(PEDAL_FULL_SCALE) : quo_q[SCL_W-1:0]);

	`PPFM_ASSERT_NOW(a_done_ends_run, done_q, !run_q, "lane reports done while still dividing")

endmodule

FILE: rtl/ppfm_merge.sv
// Merging stage: cross-channel checks, fault latches, fault mask, mode and torque.
`include "pedal_plausibility_fault_manager_unit_macros.svh"

module ppfm_merge (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 commit,
	input  ppfm_pkg::lane_out_t  left_i,
	input  ppfm_pkg::lane_out_t  right_i,
	input  ppfm_pkg::flags_t     flags_i,
	input  ppfm_pkg::cfg_t       cfg_i,
	output ppfm_pkg::res_t       res_o
);
	import ppfm_pkg::*;

	logic [TIM_W-1:0]  count_q;
	logic              apps_q;
	logic              overlap_q;
	logic              cal_bad;
	logic [SCL_W-1:0]  ls;
	logic [SCL_W-1:0]  rs;
	logic              loor;
	logic              roor;
	logic [SCL_W-1:0]  diff;
	logic [SCL_W-1:0]  lower;
	logic [CMP_W-1:0]  ls_w;
	logic [CMP_W-1:0]  rs_w;
	logic [CMP_W-1:0]  lower_w;
	logic              mism;
	logic              implaus;
	logic [TIM_W-1:0]  count_next;
	logic              apps_next;
	logic              overlap_next;
	logic [MASK_W-1:0] mask;
	drive_mode_t       mode;
	logic [TQ_W-1:0]   tq_raw;
	logic [TQ_W-1:0]   tq_sel;

	// A bad calibration forces both channels to zero and out of range.
	assign cal_bad = (cfg_i.left_max <= cfg_i.left_min) || (cfg_i.right_max <= cfg_i.right_min);
	assign ls      = cal_bad ? '0 : left_i.scaled;
	assign rs      = cal_bad ? '0 : right_i.scaled;
	assign loor    = cal_bad | left_i.oor;
	assign roor    = cal_bad | right_i.oor;

	// Channel agreement and the lower of the two readings.
	assign diff    = (ls > rs) ? ls - rs : rs - ls;
	assign lower   = (ls < rs) ? ls : rs;
	assign ls_w    = CMP_W'(ls);
	assign rs_w    = CMP_W'(rs);
	assign lower_w = CMP_W'(lower);
	assign mism    = CMP_W'(diff) > CMP_W'(cfg_i.mismatch_limit);

	// Brake/throttle overlap latch with hysteresis.
	always_comb begin
		overlap_next = overlap_q;
		if (overlap_q) begin
			if (lower_w <= CMP_W'(cfg_i.overlap_low)) begin
				overlap_next = 1'b0;
			end
		end else if (flags_i.brake && (lower_w >= CMP_W'(cfg_i.overlap_high))) begin
			overlap_next = 1'b1;
		end
	end

	// Saturating implausibility timer and the permanent timeout latch.
	assign implaus    = loor | roor | mism;
	assign count_next = !implaus ? '0 : ((&count_q) ? count_q : count_q + 1'b1);
	assign apps_next  = apps_q | (implaus && (count_next >= cfg_i.time_limit));

	// Fault mask and drive mode.
	always_comb begin
		mask                    = '0;
		mask[MASK_BSPD_LATCH]   = flags_i.bspd;
		mask[MASK_BSPD_OPEN]    = !flags_i.seg_closed;
		mask[MASK_INERTIA_OPEN] = !flags_i.inertia;
		mask[MASK_LEFT_OOR]     = loor;
		mask[MASK_RIGHT_OOR]    = roor;
		mask[MASK_MISMATCH]     = mism;
		mask[MASK_TIMEOUT]      = apps_next;
		mask[MASK_OVERLAP]      = overlap_next;
		if (mask != '0) begin
			mode = MODE_FAULT;
		end else if (flags_i.brake) begin
			mode = MODE_BRAKING;
		end else begin
			mode = MODE_RUN;
		end
	end

	// Torque with idle deadband and top clamp, only in run mode.
	assign tq_raw = TQ_W'(lower) * TQ_W'(TORQUE_SCALE);
	always_comb begin
		if (mode != MODE_RUN) begin
			tq_sel = '0;
		end else if (tq_raw < TQ_W'(TORQUE_DEADBAND)) begin
			tq_sel = '0;
		end else if (tq_raw > TQ_W'(TORQUE_KNEE)) begin
			tq_sel = TQ_W'(TORQUE_CEIL);
		end else begin
			tq_sel = tq_raw;
		end
	end

	assign res_o.left_scaled  = ls_w[OUT_W-1:0];
	assign res_o.right_scaled = rs_w[OUT_W-1:0];
	assign res_o.fault_mask   = mask;
	assign res_o.drive_mode   = mode;
	assign res_o.torque       = tq_sel[TRQ_OUT_W-1:0];
	assign res_o.cal_bad      = cal_bad;
	assign res_o.elapsed      = count_next;

	// Fault state advances once per sample, when its result is committed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			apps_q    <= 1'b0;
			overlap_q <= 1'b0;
		end else if (commit) begin
			count_q   <= count_next;
			apps_q    <= apps_next;
			overlap_q <= overlap_next;
		end
	end

	`PPFM_ASSERT_NEXT(a_timeout_sticky, apps_q, apps_q, "timeout latch cleared without reset")

endmodule

FILE: rtl/pedal_plausibility_fault_manager_unit.sv
// Top level of the dual-channel pedal plausibility check and fault manager.
// Usage:
// - Configuration: write register cfg_index with cfg_data on the cfg channel
//   (cfg_ready is always high). Write only while no sample is in flight.
// - Input: one transaction per 1 ms sample on in_valid/in_ready carrying two
//   12-bit pedal readings and the brake and shutdown-chain flags.
// - Output: one transaction per sample on out_valid/out_ready with scaled
//   pedals, fault mask, drive mode, torque request and diagnostics.
// - Both channels are scaled at once by two lanes, each a bit-serial divider
//   taking one quotient bit per cycle (18 bits with the default full scale).
// - Sequencing: both lanes divide, then the result is committed to the output
//   register and out_valid rises; a new sample is taken only after that commit.
// - While out_ready is low the result waits in the output register; the
//   next sample is still taken and divided, then waits in the lanes until the
//   output register frees, and in_ready stays low meanwhile.
// - Reset clears the fault timer and both latches, loads the default
//   calibration and leaves the block ready for input with no result pending.
`include "pedal_plausibility_fault_manager_unit_macros.svh"

module pedal_plausibility_fault_manager_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ppfm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ppfm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [ppfm_pkg::RAW_W-1:0]      left_raw,
	input  logic [ppfm_pkg::RAW_W-1:0]      right_raw,
	input  logic                            brake_on,
	input  logic                            bspd_tripped,
	input  logic                            bspd_segment_closed,
	input  logic                            inertia_closed,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ppfm_pkg::OUT_W-1:0]      left_scaled,
	output logic [ppfm_pkg::OUT_W-1:0]      right_scaled,
	output logic [ppfm_pkg::MASK_W-1:0]     fault_mask,
	output logic [1:0]                      drive_mode,
	output logic [ppfm_pkg::TRQ_OUT_W-1:0]  torque_request,
	output logic                            calibration_bad,
	output logic [ppfm_pkg::TIM_W-1:0]      implaus_elapsed
);
	import ppfm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_HOLD
	} state_t;

	state_t    state_q;
	cfg_t      cfg_q;
	flags_t    flags_q;
	lane_out_t lane_l;
	lane_out_t lane_r;
	res_t      res;
	res_t      out_q;
	logic      out_valid_q;
	logic      in_fire;
	logic      commit;

	assign cfg_ready = 1'b1;
	assign in_ready  = state_q == ST_IDLE;
	assign in_fire   = in_valid && in_ready;
	assign commit    = (state_q == ST_HOLD) && (!out_valid_q || out_ready);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_min       <= '0;
			cfg_q.left_max       <= '1;
			cfg_q.right_min      <= '0;
			cfg_q.right_max      <= '1;
			cfg_q.mismatch_limit <= MIS_W'(25);
			cfg_q.time_limit     <= TIM_W'(100);
			cfg_q.overlap_high   <= OUT_W'(64);
			cfg_q.overlap_low    <= OUT_W'(13);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				REG_LEFT_MIN:     cfg_q.left_min       <= cfg_data[CNT_W-1:0];
				REG_LEFT_MAX:     cfg_q.left_max       <= cfg_data[CNT_W-1:0];
				REG_RIGHT_MIN:    cfg_q.right_min      <= cfg_data[CNT_W-1:0];
				REG_RIGHT_MAX:    cfg_q.right_max      <= cfg_data[CNT_W-1:0];
				REG_MISMATCH:     cfg_q.mismatch_limit <= cfg_data[MIS_W-1:0];
				REG_TIME_LIMIT:   cfg_q.time_limit     <= cfg_data[TIM_W-1:0];
				REG_OVERLAP_HIGH: cfg_q.overlap_high   <= cfg_data[OUT_W-1:0];
				REG_OVERLAP_LOW:  cfg_q.overlap_low    <= cfg_data[OUT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Discrete flags of the accepted sample.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			flags_q.brake      <= brake_on;
			flags_q.bspd       <= bspd_tripped;
			flags_q.seg_closed <= bspd_segment_closed;
			flags_q.inertia    <= inertia_closed;
		end
	end

	// Two scaling lanes, started together on each accepted sample.
	ppfm_lane u_lane_left (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_fire),
		.raw    (left_raw),
		.lo     (cfg_q.left_min),
		.hi     (cfg_q.left_max),
		.lane_o (lane_l)
	);

	ppfm_lane u_lane_right (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_fire),
		.raw    (right_raw),
		.lo     (cfg_q.right_min),
		.hi     (cfg_q.right_max),
		.lane_o (lane_r)
	);

	ppfm_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.commit  (commit),
		.left_i  (lane_l),
		.right_i (lane_r),
		.flags_i (flags_q),
		.cfg_i   (cfg_q),
		.res_o   (res)
	);

	// Sample sequencing and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_DIVIDE;
					end
				end
				ST_DIVIDE: begin
					if (lane_l.done) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (commit) begin
			out_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign left_scaled     = out_q.left_scaled;
	assign right_scaled    = out_q.right_scaled;
	assign fault_mask      = out_q.fault_mask;
	assign drive_mode      = out_q.drive_mode;
	assign torque_request  = out_q.torque;
	assign calibration_bad = out_q.cal_bad;
	assign implaus_elapsed = out_q.elapsed;

	`PPFM_ASSERT_NOW(a_lanes_in_step, 1'b1, lane_l.done == lane_r.done, "lanes finished apart")
	`PPFM_ASSERT_NOW(a_done_while_divide, lane_l.done, state_q == ST_DIVIDE, "lane done outside divide")
	`PPFM_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready, "input taken again while dividing")

endmodule

FILE: tb/pedal_plausibility_fault_manager_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the pedal plausibility fault manager unit.
module pedal_plausibility_fault_manager_unit_tb;
	import ppfm_pkg::*;

	// One pedal sample as it is driven onto the input channel.
	typedef struct packed {
		logic [RAW_W-1:0] left;
		logic [RAW_W-1:0] right;
		logic             brake;
		logic             bspd;
		logic             seg_closed;
		logic             inertia;
	} pedal_sample_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [RAW_W-1:0]      left_raw = '0;
	logic [RAW_W-1:0]      right_raw = '0;
	logic                  brake_on = 1'b0;
	logic                  bspd_tripped = 1'b0;
	logic                  bspd_segment_closed = 1'b1;
	logic                  inertia_closed = 1'b1;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [OUT_W-1:0]      left_scaled;
	logic [OUT_W-1:0]      right_scaled;
	logic [MASK_W-1:0]     fault_mask;
	logic [1:0]            drive_mode;
	logic [TRQ_OUT_W-1:0]  torque_request;
	logic                  calibration_bad;
	logic [TIM_W-1:0]      implaus_elapsed;

	// Predictor copy of the calibration registers and the fault state.
	cfg_t        cal;
	int unsigned implaus_run;
	bit          timeout_latched;
	bit          overlap_latched;

	res_t predicted_reports[$];
	bit   idle_on = 1'b0;
	int   stall_left = 0;
	int   error_count = 0;
	int   samples_sent = 0;
	int   reports_checked = 0;
	int   setups_used = 0;

	pedal_plausibility_fault_manager_unit dut (.*);

	always #1 clk = ~clk;

	// Watchdog against a hung handshake.
	initial begin
		#2_000_000;
		$display("Timeout: the block stopped completing transactions.");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Receiver side: random stall bursts while idling is enabled.
	always @(posedge clk) begin
		if (!arst_n || !idle_on) begin
			stall_left = 0;
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 9);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("ERROR at %0t: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got)
			report_error($sformatf("%s expected %0d got %0d", name, want, got));
	endtask

	// Each output transaction is compared with the oldest predicted report.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (predicted_reports.size() == 0) begin
				report_error("output transaction with no prediction pending");
			end else begin
				want = predicted_reports.pop_front();
				reports_checked++;
				check_field("left_scaled", want.left_scaled, left_scaled);
				check_field("right_scaled", want.right_scaled, right_scaled);
				check_field("fault_mask", want.fault_mask, fault_mask);
				check_field("drive_mode", want.drive_mode, drive_mode);
				check_field("torque_request", want.torque, torque_request);
				check_field("calibration_bad", want.cal_bad, calibration_bad);
				check_field("implaus_elapsed", want.elapsed, implaus_elapsed);
			end
		end
	end

	// Maps one downshifted reading onto pedal travel; returns the clip flag.
	function automatic bit scale_pedal(input int unsigned reading, input int unsigned lo,
			input int unsigned hi, output int unsigned travel);
		int unsigned q;
		if (reading < lo) begin
			travel = 0;
			return 1'b1;
		end
		q = (reading - lo) * PEDAL_FULL_SCALE / (hi - lo);
		if (q > PEDAL_FULL_SCALE) begin
			travel = PEDAL_FULL_SCALE;
			return 1'b1;
		end
		travel = q;
		return 1'b0;
	endfunction

	// Advances the predicted fault state by one sample and builds its report.
	function automatic res_t predict_pedal_step(input pedal_sample_t s);
		res_t        r;
		int unsigned lt, rt, gap, lower, trq;
		bit          lo_oor, ro_oor, too_far, bad_cal;
		bad_cal = (cal.left_max <= cal.left_min) || (cal.right_max <= cal.right_min);
		if (bad_cal) begin
			lt = 0;
			rt = 0;
			lo_oor = 1'b1;
			ro_oor = 1'b1;
		end else begin
			lo_oor = scale_pedal(s.left >> 2, cal.left_min, cal.left_max, lt);
			ro_oor = scale_pedal(s.right >> 2, cal.right_min, cal.right_max, rt);
		end
		gap = (lt > rt) ? lt - rt : rt - lt;
		too_far = gap > cal.mismatch_limit;
		lower = (lt < rt) ? lt : rt;

		// Overlap latch with hysteresis; once set it ignores the brake.
		if (overlap_latched) begin
			if (lower <= cal.overlap_low)
				overlap_latched = 1'b0;
		end else if (s.brake && lower >= cal.overlap_high) begin
			overlap_latched = 1'b1;
		end

		// Saturating implausibility timer and its permanent latch.
		if (lo_oor || ro_oor || too_far) begin
			if (implaus_run < 32'hFFFF)
				implaus_run++;
			if (implaus_run >= cal.time_limit)
				timeout_latched = 1'b1;
		end else begin
			implaus_run = 0;
		end

		r.fault_mask = '0;
		r.fault_mask[MASK_BSPD_LATCH] = s.bspd;
		r.fault_mask[MASK_BSPD_OPEN] = !s.seg_closed;
		r.fault_mask[MASK_INERTIA_OPEN] = !s.inertia;
		r.fault_mask[MASK_LEFT_OOR] = lo_oor;
		r.fault_mask[MASK_RIGHT_OOR] = ro_oor;
		r.fault_mask[MASK_MISMATCH] = too_far;
		r.fault_mask[MASK_TIMEOUT] = timeout_latched;
		r.fault_mask[MASK_OVERLAP] = overlap_latched;

		if (r.fault_mask != '0)
			r.drive_mode = MODE_FAULT;
		else if (s.brake)
			r.drive_mode = MODE_BRAKING;
		else
			r.drive_mode = MODE_RUN;

		// Torque with idle deadband and clamp, only in run mode.
		trq = 0;
		if (r.drive_mode == MODE_RUN) begin
			trq = lower * TORQUE_SCALE;
			if (trq < TORQUE_DEADBAND)
				trq = 0;
			else if (trq > TORQUE_KNEE)
				trq = TORQUE_CEIL;
		end

		r.left_scaled = OUT_W'(lt);
		r.right_scaled = OUT_W'(rt);
		r.torque = TRQ_OUT_W'(trq);
		r.cal_bad = bad_cal;
		r.elapsed = TIM_W'(implaus_run);
		return r;
	endfunction

	// Sends one sample transaction, with a random gap ahead of it while idling.
	task automatic send_sample(input pedal_sample_t s);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		left_raw <= s.left;
		right_raw <= s.right;
		brake_on <= s.brake;
		bspd_tripped <= s.bspd;
		bspd_segment_closed <= s.seg_closed;
		inertia_closed <= s.inertia;
		do @(posedge clk); while (!in_ready);
		predicted_reports.push_back(predict_pedal_step(s));
		samples_sent++;
	endtask

	task automatic send_pedals(input int unsigned l, input int unsigned r,
			input bit brake = 1'b0, input bit bspd = 1'b0, input bit seg = 1'b1,
			input bit inertia = 1'b1);
		pedal_sample_t s;
		s.left = RAW_W'(l);
		s.right = RAW_W'(r);
		s.brake = brake;
		s.bspd = bspd;
		s.seg_closed = seg;
		s.inertia = inertia;
		send_sample(s);
	endtask

	// Register write once the block has drained; unused data bits are random.
	task automatic write_reg(input cfg_idx_t idx, input int unsigned value);
		logic [CFG_DATA_W-1:0] data;
		data = CFG_DATA_W'($urandom);
		case (idx)
			REG_TIME_LIMIT: data = value[15:0];
			REG_MISMATCH, REG_OVERLAP_HIGH, REG_OVERLAP_LOW: data[7:0] = value[7:0];
			default: data[CNT_W-1:0] = value[CNT_W-1:0];
		endcase
		in_valid <= 1'b0;
		while (predicted_reports.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_LEFT_MIN: cal.left_min = data[CNT_W-1:0];
			REG_LEFT_MAX: cal.left_max = data[CNT_W-1:0];
			REG_RIGHT_MIN: cal.right_min = data[CNT_W-1:0];
			REG_RIGHT_MAX: cal.right_max = data[CNT_W-1:0];
			REG_MISMATCH: cal.mismatch_limit = data[MIS_W-1:0];
			REG_TIME_LIMIT: cal.time_limit = data[TIM_W-1:0];
			REG_OVERLAP_HIGH: cal.overlap_high = data[OUT_W-1:0];
			REG_OVERLAP_LOW: cal.overlap_low = data[OUT_W-1:0];
			default: begin
			end
		endcase
	endtask

	task automatic program_setup(input int unsigned lmin, input int unsigned lmax,
			input int unsigned rmin, input int unsigned rmax, input int unsigned mis,
			input int unsigned tlim, input int unsigned hi, input int unsigned lo);
		write_reg(REG_LEFT_MIN, lmin);
		write_reg(REG_LEFT_MAX, lmax);
		write_reg(REG_RIGHT_MIN, rmin);
		write_reg(REG_RIGHT_MAX, rmax);
		write_reg(REG_MISMATCH, mis);
		write_reg(REG_TIME_LIMIT, tlim);
		write_reg(REG_OVERLAP_HIGH, hi);
		write_reg(REG_OVERLAP_LOW, lo);
		setups_used++;
	endtask

	// Mostly tracking pedals inside the calibrated span, with some wild samples.
	function automatic pedal_sample_t make_pedal_sample(input bit well_formed);
		pedal_sample_t s;
		int unsigned   f, g, lr, rr, lspan, rspan;
		bit            cal_ok;
		cal_ok = (cal.left_max > cal.left_min) && (cal.right_max > cal.right_min);
		if (well_formed && cal_ok) begin
			lspan = cal.left_max - cal.left_min;
			rspan = cal.right_max - cal.right_min;
			f = $urandom_range(0, 1000);
			g = f + $urandom_range(0, 60);
			g = (g < 30) ? 0 : ((g - 30 > 1000) ? 1000 : g - 30);
			lr = cal.left_min + f * lspan / 1000;
			rr = cal.right_min + g * rspan / 1000;
			if ($urandom_range(0, 9) == 0)
				lr = $urandom_range(0, 1023);
			s.left = RAW_W'(lr * 4 + $urandom_range(0, 3));
			s.right = RAW_W'(rr * 4 + $urandom_range(0, 3));
			s.brake = ($urandom_range(0, 3) == 0);
			s.bspd = ($urandom_range(0, 19) == 0);
			s.seg_closed = ($urandom_range(0, 19) != 0);
			s.inertia = ($urandom_range(0, 19) != 0);
		end else begin
			s.left = RAW_W'($urandom_range(0, 4095));
			s.right = RAW_W'($urandom_range(0, 4095));
			s.brake = 1'($urandom_range(0, 1));
			s.bspd = 1'($urandom_range(0, 1));
			s.seg_closed = 1'($urandom_range(0, 1));
			s.inertia = 1'($urandom_range(0, 1));
		end
		return s;
	endfunction

	// Random samples; idling switches on and off in stretches of 40.
	task automatic run_random_items(input int n);
		for (int i = 0; i < n; i++) begin
			idle_on <= ((i / 40) % 2 == 0);
			send_sample(make_pedal_sample($urandom_range(0, 4) != 0));
		end
	endtask

	// Reset calibration: full-scale pedals, mismatch, overlap and chain flags.
	task automatic test_default_config;
		send_pedals(0, 0);
		send_pedals(4095, 4095);
		send_pedals(4095, 0);
		send_pedals(0, 4095);
		send_pedals(2048, 2100);
		send_pedals(2048, 2048, 1'b1);
		send_pedals(2048, 2048, 1'b0);
		send_pedals(3, 3);
		send_pedals(1000, 1000, 1'b1);
		send_pedals(1000, 1000, 1'b0, 1'b1);
		send_pedals(1000, 1000, 1'b0, 1'b0, 1'b0);
		send_pedals(1000, 1000, 1'b0, 1'b0, 1'b1, 1'b0);
	endtask

	// A 0..255 span makes travel equal the reading, so torque edges are exact.
	task automatic test_torque_shaping;
		program_setup(0, 255, 0, 255, 10, 65535, 255, 0);
		send_pedals(4, 5);
		send_pedals(11, 8);
		send_pedals(920, 923);
		send_pedals(927, 924);
		send_pedals(400, 440);
		send_pedals(400, 444);
		send_pedals(1024, 4095);
	endtask

	// Invalid calibration on either side, then the narrowest valid spans.
	task automatic test_calibration_limits;
		program_setup(500, 500, 0, 1023, 25, 65535, 64, 13);
		send_pedals(2000, 2000);
		send_pedals(4095, 0);
		program_setup(0, 1023, 900, 100, 25, 65535, 64, 13);
		send_pedals(1000, 1000);
		program_setup(1022, 1023, 0, 1, 255, 65535, 255, 0);
		send_pedals(4095, 0);
		send_pedals(4088, 4);
		send_pedals(4084, 7);
	endtask

	// Overlap latch set and clear thresholds, including both extremes.
	task automatic test_overlap_hysteresis;
		program_setup(0, 255, 0, 255, 255, 65535, 100, 40);
		send_pedals(396, 396, 1'b1);
		send_pedals(400, 400, 1'b1);
		send_pedals(164, 164, 1'b0);
		send_pedals(160, 160, 1'b0);
		write_reg(REG_OVERLAP_HIGH, 0);
		write_reg(REG_OVERLAP_LOW, 0);
		send_pedals(0, 0, 1'b1);
		send_pedals(0, 0, 1'b0);
		write_reg(REG_OVERLAP_HIGH, 255);
		write_reg(REG_OVERLAP_LOW, 255);
		send_pedals(1020, 1020, 1'b1);
		send_pedals(1020, 1020, 1'b0);
	endtask

	// Random traffic over several register setups, extremes among them.
	task automatic test_random_traffic;
		int unsigned a, b, hi;
		for (int k = 0; k < 6; k++) begin
			case (k)
				0: begin
					hi = $urandom_range(20, 200);
					program_setup($urandom_range(0, 300), $urandom_range(700, 1023),
						$urandom_range(0, 300), $urandom_range(700, 1023),
						$urandom_range(10, 60), 65535, hi, $urandom_range(0, hi));
					run_random_items(120);
				end
				1: begin
					program_setup(0, 1023, 0, 1023, 0, 65535, 255, 0);
					run_random_items(100);
				end
				2: begin
					program_setup(1022, 1023, 0, 1, 255, 65535, 0, 255);
					run_random_items(60);
				end
				3: begin
					program_setup($urandom_range(0, 511), $urandom_range(512, 1023),
						$urandom_range(0, 511), $urandom_range(512, 1023),
						$urandom_range(0, 255), $urandom_range(1000, 65535),
						$urandom_range(0, 255), $urandom_range(0, 255));
					run_random_items(120);
				end
				4: begin
					a = $urandom_range(600, 1023);
					b = $urandom_range(0, a);
					program_setup(a, b, 0, 1023, 25, 65535, 64, 13);
					run_random_items(20);
				end
				default: begin
					program_setup(0, 255, 0, 255, $urandom_range(0, 255), 65535,
						$urandom_range(0, 255), $urandom_range(0, 255));
					run_random_items(150);
				end
			endcase
		end
	endtask

	// The permanent timeout latch goes last, with no idling on either side.
	task automatic test_timeout_latch;
		idle_on <= 1'b0;
		program_setup(0, 255, 0, 255, 5, 3, 200, 0);
		send_pedals(200, 200);
		send_pedals(200, 400);
		send_pedals(200, 400);
		send_pedals(200, 200);
		send_pedals(200, 400);
		send_pedals(400, 200);
		send_pedals(200, 400);
		write_reg(REG_TIME_LIMIT, 0);
		for (int i = 0; i < 40; i++)
			send_sample(make_pedal_sample($urandom_range(0, 4) != 0));
	endtask

	// Main sequence: reset once, run each test, drain and report.
	initial begin
		cal.left_min = '0;
		cal.left_max = 10'd1023;
		cal.right_min = '0;
		cal.right_max = 10'd1023;
		cal.mismatch_limit = 8'd25;
		cal.time_limit = 16'd100;
		cal.overlap_high = 8'd64;
		cal.overlap_low = 8'd13;
		implaus_run = 0;
		timeout_latched = 1'b0;
		overlap_latched = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_on <= 1'b1;

		test_default_config();
		test_torque_shaping();
		test_calibration_limits();
		test_overlap_hysteresis();
		test_random_traffic();
		test_timeout_latch();

		in_valid <= 1'b0;
		while (predicted_reports.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("Run covered %0d pedal samples and %0d checked reports over %0d setups.",
			samples_sent, reports_checked, setups_used);
		$display("It exercised bad calibration, torque edges, overlap hysteresis and the timeout latch.");
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Mismatches found: %0d", error_count);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

FILE: pedal_plausibility_fault_manager_unit.f
+incdir+rtl
rtl/ppfm_pkg.sv
rtl/ppfm_lane.sv
rtl/ppfm_merge.sv
rtl/pedal_plausibility_fault_manager_unit.sv
tb/pedal_plausibility_fault_manager_unit_tb.sv
